// ===== hw/rtl/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared sizes, command and status codes and sequencer states of the
// dominator tree builder.
// ----------------------------------------------------------------------------
package dtb_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int NV        = MAX_NODES + 1;
    localparam int AW        = $clog2(NV);
    localparam int AW1       = AW + 1;
    localparam int VW        = $clog2(NV + 1);
    localparam int EW        = $clog2(MAX_EDGES);
    localparam int ETW       = $clog2(MAX_EDGES + 1);
    localparam int SW        = AW + ETW;
    localparam int NCW       = 9;
    localparam int FW        = 8;
    localparam int EDW       = 2 * FW;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_DONE = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE, S_QUERY, S_CLEAR, S_INIT,
        D_SCAN, D_LOAD, D_EDGE, D_CHK,
        W_START, W_VTX, W_SEMI,
        P_SCAN, P_EDGE, P_SV, P_UPD,
        B_HEAD, B_LINK,
        L_B, L_C, L_0, L_1, L_2, L_3, L_4, L_5, L_6,
        L_E1, L_E2, L_E3, L_F, L_F2,
        K_1, K_2, K_4, K_5, K_6,
        F_0, F_1, F_2, F_3, F_END,
        E_0, E_1, E_RETL, C_1,
        U_0, U_1, U_2, U_3, U_4, U_5, U_6,
        E_3, E_4, E_5, E_6, E_7
    } state_t;

endpackage

// ===== hw/rtl/dtb_ram.sv =====
// ----------------------------------------------------------------------------
// dtb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ===== hw/rtl/dominator_tree_builder.sv =====
// ----------------------------------------------------------------------------
// dominator_tree_builder
// Edge store and Lengauer-Tarjan dominator computation with balanced link
// and path compression, run by one sequencer over one-write, one-read tables.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  command  | start, busy            | command, edge_source, edge_target, query_node
//  result   | done (one cycle)       | status, immediate_dominator, has_dominator, reachable
//  config   | cfg_valid, cfg_ready   | cfg_data (node_count)
//
//  clear and add: the result comes in the next cycle, and the next word is taken at once.
//  query: from idle for node 0 or an error, else through S_QUERY; compute:
//  clears the semidominator, bucket and dominator tables, then walks the
//  graph, bounded by the edge store scans and one-read-per-cycle table ports.
//  rst_n is asynchronous and clears the control state; the tables are not.
//  the receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module dominator_tree_builder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [dtb_pkg::FW-1:0]   edge_source,
    input  logic [dtb_pkg::FW-1:0]   edge_target,
    input  logic [dtb_pkg::FW-1:0]   query_node,
    output logic                     done,
    output logic [1:0]               status,
    output logic [dtb_pkg::FW-1:0]   immediate_dominator,
    output logic                     has_dominator,
    output logic                     reachable,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [dtb_pkg::NCW-1:0]  cfg_data
);

    import dtb_pkg::*;

    state_t state_reg, state_next;
    logic [NCW-1:0] ncount_reg;
    logic [ETW-1:0] etotal_reg, etotal_next;
    logic computed_reg, computed_next;
    logic done_reg, done_next;
    status_t status_reg, status_next;
    logic [FW-1:0] idom_out_reg, idom_out_next;
    logic has_reg, has_next, reach_reg, reach_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] v_reg, v_next;
    logic [ETW-1:0] c_reg, c_next;
    logic [AW-1:0] w_reg, w_next;
    logic [AW-1:0] sw_reg, sw_next;
    logic [ETW-1:0] e_reg, e_next;
    logic [VW-1:0] i_reg, i_next;
    logic [AW-1:0] ev_reg, ev_next;
    logic ret_bucket_reg, ret_bucket_next;
    logic [AW-1:0] cv_reg, cv_next;
    logic [AW-1:0] av_reg, av_next;
    logic [AW-1:0] ctop_reg, ctop_next;
    logic [AW-1:0] u_reg, u_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] la_reg, la_next;
    logic [AW-1:0] lu_reg, lu_next;
    logic [AW-1:0] aa_reg, aa_next;
    logic [AW-1:0] sla_reg, sla_next;
    logic [AW-1:0] er_reg, er_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] cc_reg, cc_next;
    logic [AW-1:0] lw_reg, lw_next;
    logic [AW-1:0] slw_reg, slw_next;
    logic [AW-1:0] ss_reg, ss_next;
    logic [AW-1:0] scc_reg, scc_next;
    logic [AW-1:0] par_reg, par_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] x_reg, x_next;

    logic [NCW-1:0] n_eff;

    logic edge_we;
    logic [EW-1:0] edge_wa, edge_ra;
    logic [EDW-1:0] edge_wd, edge_rd;
    logic stack_we;
    logic [AW-1:0] stack_wa, stack_ra;
    logic [SW-1:0] stack_wd, stack_rd;
    logic parent_we, semi_we, vertex_we, label_we, size_we;
    logic anc_we, child_we, idom_we, bhead_we, bnext_we;
    logic [AW-1:0] parent_wa, semi_wa, vertex_wa, label_wa, size_wa;
    logic [AW-1:0] anc_wa, child_wa, idom_wa, bhead_wa, bnext_wa;
    logic [AW-1:0] parent_wd, semi_wd, vertex_wd, label_wd, size_wd;
    logic [AW-1:0] anc_wd, child_wd, idom_wd, bhead_wd, bnext_wd;
    logic [AW-1:0] parent_ra, semi_ra, vertex_ra, label_ra, size_ra;
    logic [AW-1:0] anc_ra, child_ra, idom_ra, bhead_ra, bnext_ra;
    logic [AW-1:0] parent_rd, semi_rd, vertex_rd, label_rd, size_rd;
    logic [AW-1:0] anc_rd, child_rd, idom_rd, bhead_rd, bnext_rd;

    assign n_eff = (ncount_reg == '0) ? NCW'(1) :
                   (ncount_reg > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : ncount_reg;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign immediate_dominator = idom_out_reg;
    assign has_dominator = has_reg;
    assign reachable = reach_reg;

    dtb_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
        .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
        .raddr(edge_ra), .rdata(edge_rd));
    dtb_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack (
        .clk(clk), .we(stack_we), .waddr(stack_wa), .wdata(stack_wd),
        .raddr(stack_ra), .rdata(stack_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_parent (
        .clk(clk), .we(parent_we), .waddr(parent_wa), .wdata(parent_wd),
        .raddr(parent_ra), .rdata(parent_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_semi (
        .clk(clk), .we(semi_we), .waddr(semi_wa), .wdata(semi_wd),
        .raddr(semi_ra), .rdata(semi_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_vertex (
        .clk(clk), .we(vertex_we), .waddr(vertex_wa), .wdata(vertex_wd),
        .raddr(vertex_ra), .rdata(vertex_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_label (
        .clk(clk), .we(label_we), .waddr(label_wa), .wdata(label_wd),
        .raddr(label_ra), .rdata(label_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_size (
        .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
        .raddr(size_ra), .rdata(size_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_anc (
        .clk(clk), .we(anc_we), .waddr(anc_wa), .wdata(anc_wd),
        .raddr(anc_ra), .rdata(anc_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_child (
        .clk(clk), .we(child_we), .waddr(child_wa), .wdata(child_wd),
        .raddr(child_ra), .rdata(child_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_idom (
        .clk(clk), .we(idom_we), .waddr(idom_wa), .wdata(idom_wd),
        .raddr(idom_ra), .rdata(idom_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_bhead (
        .clk(clk), .we(bhead_we), .waddr(bhead_wa), .wdata(bhead_wd),
        .raddr(bhead_ra), .rdata(bhead_rd));
    dtb_ram #(.WIDTH(AW), .DEPTH(NV)) u_bnext (
        .clk(clk), .we(bnext_we), .waddr(bnext_wa), .wdata(bnext_wd),
        .raddr(bnext_ra), .rdata(bnext_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ncount_reg   <= NCW'(1);
            etotal_reg   <= '0;
            computed_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            etotal_reg   <= etotal_next;
            computed_reg <= computed_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                ncount_reg   <= cfg_data;
                computed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        idom_out_reg   <= idom_out_next;
        has_reg        <= has_next;
        reach_reg      <= reach_next;
        clr_reg        <= clr_next;
        cnt_reg        <= cnt_next;
        top_reg        <= top_next;
        v_reg          <= v_next;
        c_reg          <= c_next;
        w_reg          <= w_next;
        sw_reg         <= sw_next;
        e_reg          <= e_next;
        i_reg          <= i_next;
        ev_reg         <= ev_next;
        ret_bucket_reg <= ret_bucket_next;
        cv_reg         <= cv_next;
        av_reg         <= av_next;
        ctop_reg       <= ctop_next;
        u_reg          <= u_next;
        a_reg          <= a_next;
        la_reg         <= la_next;
        lu_reg         <= lu_next;
        aa_reg         <= aa_next;
        sla_reg        <= sla_next;
        er_reg         <= er_next;
        s_reg          <= s_next;
        cc_reg         <= cc_next;
        lw_reg         <= lw_next;
        slw_reg        <= slw_next;
        ss_reg         <= ss_next;
        scc_reg        <= scc_next;
        par_reg        <= par_next;
        b_reg          <= b_next;
        x_reg          <= x_next;
    end

    always_comb
    begin
        logic [FW-1:0] es;
        logic [FW-1:0] et;
        logic          e_ok;
        logic          visit_en;
        logic [AW-1:0] vis_v;
        logic [AW-1:0] vis_num;
        logic [AW-1:0] res;

        state_next      = state_reg;
        etotal_next     = etotal_reg;
        computed_next   = computed_reg;
        done_next       = 1'b0;
        status_next     = ST_OK;
        idom_out_next   = '0;
        has_next        = 1'b0;
        reach_next      = 1'b0;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        top_next        = top_reg;
        v_next          = v_reg;
        c_next          = c_reg;
        w_next          = w_reg;
        sw_next         = sw_reg;
        e_next          = e_reg;
        i_next          = i_reg;
        ev_next         = ev_reg;
        ret_bucket_next = ret_bucket_reg;
        cv_next         = cv_reg;
        av_next         = av_reg;
        ctop_next       = ctop_reg;
        u_next          = u_reg;
        a_next          = a_reg;
        la_next         = la_reg;
        lu_next         = lu_reg;
        aa_next         = aa_reg;
        sla_next        = sla_reg;
        er_next         = er_reg;
        s_next          = s_reg;
        cc_next         = cc_reg;
        lw_next         = lw_reg;
        slw_next        = slw_reg;
        ss_next         = ss_reg;
        scc_next        = scc_reg;
        par_next        = par_reg;
        b_next          = b_reg;
        x_next          = x_reg;

        edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
        stack_we = 1'b0; stack_wa = '0; stack_wd = '0; stack_ra = '0;
        parent_we = 1'b0; parent_wa = '0; parent_wd = '0; parent_ra = '0;
        semi_we = 1'b0; semi_wa = '0; semi_wd = '0; semi_ra = '0;
        vertex_we = 1'b0; vertex_wa = '0; vertex_wd = '0; vertex_ra = '0;
        label_we = 1'b0; label_wa = '0; label_wd = '0; label_ra = '0;
        size_we = 1'b0; size_wa = '0; size_wd = '0; size_ra = '0;
        anc_we = 1'b0; anc_wa = '0; anc_wd = '0; anc_ra = '0;
        child_we = 1'b0; child_wa = '0; child_wd = '0; child_ra = '0;
        idom_we = 1'b0; idom_wa = '0; idom_wd = '0; idom_ra = '0;
        bhead_we = 1'b0; bhead_wa = '0; bhead_wd = '0; bhead_ra = '0;
        bnext_we = 1'b0; bnext_wa = '0; bnext_wd = '0; bnext_ra = '0;

        es       = edge_rd[EDW-1:FW];
        et       = edge_rd[FW-1:0];
        e_ok     = (NCW'(es) < n_eff) && (NCW'(et) < n_eff);
        visit_en = 1'b0;
        vis_v    = '0;
        vis_num  = '0;
        res      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                semi_ra = AW'(query_node) + AW'(1);
                idom_ra = AW'(query_node) + AW'(1);
                if (start)
                begin
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            etotal_next   = '0;
                            computed_next = 1'b0;
                            done_next     = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if ((NCW'(edge_source) >= n_eff) || (NCW'(edge_target) >= n_eff))
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (etotal_reg == ETW'(MAX_EDGES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                edge_we       = 1'b1;
                                edge_wa       = etotal_reg[EW-1:0];
                                edge_wd       = {edge_source, edge_target};
                                etotal_next   = etotal_reg + ETW'(1);
                                computed_next = 1'b0;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_QUERY:
                        begin
                            if (NCW'(query_node) >= n_eff)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else if (!computed_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_DONE;
                            end
                            else if (query_node == '0)
                            begin
                                done_next  = 1'b1;
                                reach_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_QUERY;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_QUERY:
            begin
                done_next = 1'b1;
                if (semi_rd != '0)
                begin
                    idom_out_next = FW'(idom_rd - AW'(1));
                    has_next      = 1'b1;
                    reach_next    = 1'b1;
                end
                state_next = S_IDLE;
            end
            // clear semidominators, buckets and dominators; zero the sentinel
            S_CLEAR:
            begin
                semi_we = 1'b1;  semi_wa = clr_reg;
                bhead_we = 1'b1; bhead_wa = clr_reg;
                idom_we = 1'b1;  idom_wa = clr_reg;
                if (clr_reg == '0)
                begin
                    label_we = 1'b1;
                    size_we  = 1'b1;
                    anc_we   = 1'b1;
                    child_we = 1'b1;
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(NV - 1))
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                visit_en   = 1'b1;
                vis_v      = AW'(1);
                vis_num    = AW'(1);
                cnt_next   = AW'(1);
                v_next     = AW'(1);
                c_next     = '0;
                top_next   = AW'(1);
                state_next = D_SCAN;
            end
            // depth-first walk, top frame held in registers
            D_SCAN:
            begin
                if (c_reg >= etotal_reg)
                begin
                    if (top_reg == AW'(1))
                    begin
                        i_next     = VW'(cnt_reg);
                        state_next = W_START;
                    end
                    else
                    begin
                        top_next   = top_reg - AW'(1);
                        stack_ra   = top_reg - AW'(2);
                        state_next = D_LOAD;
                    end
                end
                else
                begin
                    edge_ra    = c_reg[EW-1:0];
                    state_next = D_EDGE;
                end
            end
            D_LOAD:
            begin
                v_next     = stack_rd[AW-1:0];
                c_next     = stack_rd[SW-1:AW];
                state_next = D_SCAN;
            end
            D_EDGE:
            begin
                c_next = c_reg + ETW'(1);
                if (e_ok && (AW'(es) + AW'(1) == v_reg))
                begin
                    w_next     = AW'(et) + AW'(1);
                    semi_ra    = AW'(et) + AW'(1);
                    state_next = D_CHK;
                end
                else
                begin
                    state_next = D_SCAN;
                end
            end
            D_CHK:
            begin
                if (semi_rd == '0)
                begin
                    stack_we  = 1'b1;
                    stack_wa  = top_reg - AW'(1);
                    stack_wd  = {c_reg, v_reg};
                    parent_we = 1'b1;
                    parent_wa = w_reg;
                    parent_wd = v_reg;
                    visit_en  = 1'b1;
                    vis_v     = w_reg;
                    vis_num   = cnt_reg + AW'(1);
                    cnt_next  = cnt_reg + AW'(1);
                    top_next  = top_reg + AW'(1);
                    v_next    = w_reg;
                    c_next    = '0;
                end
                state_next = D_SCAN;
            end
            // semidominator pass in reverse walk order
            W_START:
            begin
                if (i_reg < VW'(2))
                begin
                    i_next     = VW'(2);
                    state_next = F_0;
                end
                else
                begin
                    vertex_ra  = i_reg[AW-1:0];
                    state_next = W_VTX;
                end
            end
            W_VTX:
            begin
                w_next     = vertex_rd;
                semi_ra    = vertex_rd;
                state_next = W_SEMI;
            end
            W_SEMI:
            begin
                sw_next    = semi_rd;
                e_next     = '0;
                state_next = P_SCAN;
            end
            P_SCAN:
            begin
                if (e_reg >= etotal_reg)
                begin
                    vertex_ra  = sw_reg;
                    parent_ra  = w_reg;
                    state_next = B_HEAD;
                end
                else
                begin
                    edge_ra    = e_reg[EW-1:0];
                    state_next = P_EDGE;
                end
            end
            P_EDGE:
            begin
                e_next = e_reg + ETW'(1);
                if (e_ok && (AW'(et) + AW'(1) == w_reg))
                begin
                    ev_next    = AW'(es) + AW'(1);
                    semi_ra    = AW'(es) + AW'(1);
                    state_next = P_SV;
                end
                else
                begin
                    state_next = P_SCAN;
                end
            end
            P_SV:
            begin
                if (semi_rd == '0)
                begin
                    state_next = P_SCAN;
                end
                else
                begin
                    ret_bucket_next = 1'b0;
                    state_next      = E_0;
                end
            end
            P_UPD:
            begin
                if (semi_rd < sw_reg)
                begin
                    sw_next = semi_rd;
                    semi_we = 1'b1;
                    semi_wa = w_reg;
                    semi_wd = semi_rd;
                end
                state_next = P_SCAN;
            end
            B_HEAD:
            begin
                b_next     = vertex_rd;
                par_next   = parent_rd;
                bhead_ra   = vertex_rd;
                state_next = B_LINK;
            end
            B_LINK:
            begin
                bnext_we   = 1'b1;
                bnext_wa   = w_reg;
                bnext_wd   = bhead_rd;
                bhead_we   = 1'b1;
                bhead_wa   = b_reg;
                bhead_wd   = w_reg;
                label_ra   = w_reg;
                s_next     = w_reg;
                state_next = L_B;
            end
            // balanced link of w under its walk parent
            L_B:
            begin
                lw_next    = label_rd;
                semi_ra    = label_rd;
                state_next = L_C;
            end
            L_C:
            begin
                slw_next   = semi_rd;
                child_ra   = s_reg;
                state_next = L_1;
            end
            L_0:
            begin
                child_ra   = s_reg;
                state_next = L_1;
            end
            L_1:
            begin
                a_next     = child_rd;
                label_ra   = child_rd;
                child_ra   = child_rd;
                state_next = L_2;
            end
            L_2:
            begin
                cc_next    = child_rd;
                semi_ra    = label_rd;
                state_next = L_3;
            end
            L_3:
            begin
                if (slw_reg < semi_rd)
                begin
                    size_ra    = s_reg;
                    state_next = L_4;
                end
                else
                begin
                    label_we   = 1'b1;
                    label_wa   = s_reg;
                    label_wd   = lw_reg;
                    size_ra    = par_reg;
                    state_next = L_E1;
                end
            end
            L_4:
            begin
                ss_next    = size_rd;
                size_ra    = cc_reg;
                state_next = L_5;
            end
            L_5:
            begin
                scc_next   = size_rd;
                size_ra    = a_reg;
                state_next = L_6;
            end
            L_6:
            begin
                if (AW1'(ss_reg) + AW1'(scc_reg) >= {size_rd, 1'b0})
                begin
                    anc_we   = 1'b1;
                    anc_wa   = a_reg;
                    anc_wd   = s_reg;
                    child_we = 1'b1;
                    child_wa = s_reg;
                    child_wd = cc_reg;
                end
                else
                begin
                    size_we = 1'b1;
                    size_wa = a_reg;
                    size_wd = ss_reg;
                    anc_we  = 1'b1;
                    anc_wa  = s_reg;
                    anc_wd  = a_reg;
                    s_next  = a_reg;
                end
                state_next = L_0;
            end
            L_E1:
            begin
                ss_next    = size_rd;
                size_ra    = w_reg;
                state_next = L_E2;
            end
            L_E2:
            begin
                ss_next    = ss_reg + size_rd;
                scc_next   = size_rd;
                size_we    = 1'b1;
                size_wa    = par_reg;
                size_wd    = ss_reg + size_rd;
                child_ra   = par_reg;
                state_next = L_E3;
            end
            L_E3:
            begin
                if (AW1'(ss_reg) < {scc_reg, 1'b0})
                begin
                    child_we = 1'b1;
                    child_wa = par_reg;
                    child_wd = s_reg;
                    s_next   = child_rd;
                end
                state_next = L_F;
            end
            L_F:
            begin
                if (s_reg == '0)
                begin
                    bhead_ra   = par_reg;
                    state_next = K_1;
                end
                else
                begin
                    anc_we     = 1'b1;
                    anc_wa     = s_reg;
                    anc_wd     = par_reg;
                    child_ra   = s_reg;
                    state_next = L_F2;
                end
            end
            L_F2:
            begin
                s_next     = child_rd;
                state_next = L_F;
            end
            // drain the parent's bucket
            K_1:
            begin
                x_next     = bhead_rd;
                bhead_we   = 1'b1;
                bhead_wa   = par_reg;
                state_next = K_2;
            end
            K_2:
            begin
                if (x_reg == '0)
                begin
                    i_next     = i_reg - VW'(1);
                    state_next = W_START;
                end
                else
                begin
                    ev_next         = x_reg;
                    ret_bucket_next = 1'b1;
                    state_next      = E_0;
                end
            end
            K_4:
            begin
                sla_next   = semi_rd;
                semi_ra    = x_reg;
                state_next = K_5;
            end
            K_5:
            begin
                idom_we    = 1'b1;
                idom_wa    = x_reg;
                idom_wd    = (sla_reg < semi_rd) ? er_reg : par_reg;
                bnext_ra   = x_reg;
                state_next = K_6;
            end
            K_6:
            begin
                x_next     = bnext_rd;
                state_next = K_2;
            end
            // relative to immediate dominators
            F_0:
            begin
                if (i_reg > VW'(cnt_reg))
                begin
                    state_next = F_END;
                end
                else
                begin
                    vertex_ra  = i_reg[AW-1:0];
                    state_next = F_1;
                end
            end
            F_1:
            begin
                w_next     = vertex_rd;
                semi_ra    = vertex_rd;
                idom_ra    = vertex_rd;
                state_next = F_2;
            end
            F_2:
            begin
                a_next     = idom_rd;
                vertex_ra  = semi_rd;
                idom_ra    = idom_rd;
                state_next = F_3;
            end
            F_3:
            begin
                if (a_reg != vertex_rd)
                begin
                    idom_we = 1'b1;
                    idom_wa = w_reg;
                    idom_wd = idom_rd;
                end
                i_next     = i_reg + VW'(1);
                state_next = F_0;
            end
            F_END:
            begin
                idom_we       = 1'b1;
                idom_wa       = AW'(1);
                computed_next = 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            // eval with path compression
            E_0:
            begin
                anc_ra     = ev_reg;
                state_next = E_1;
            end
            E_1:
            begin
                if (anc_rd == '0)
                begin
                    label_ra   = ev_reg;
                    state_next = E_RETL;
                end
                else
                begin
                    cv_next    = ev_reg;
                    av_next    = anc_rd;
                    ctop_next  = '0;
                    anc_ra     = anc_rd;
                    state_next = C_1;
                end
            end
            E_RETL:
            begin
                er_next    = label_rd;
                semi_ra    = label_rd;
                state_next = ret_bucket_reg ? K_4 : P_UPD;
            end
            C_1:
            begin
                if (anc_rd == '0)
                begin
                    state_next = U_0;
                end
                else
                begin
                    stack_we   = 1'b1;
                    stack_wa   = ctop_reg;
                    stack_wd   = {{ETW{1'b0}}, cv_reg};
                    ctop_next  = ctop_reg + AW'(1);
                    cv_next    = av_reg;
                    av_next    = anc_rd;
                    anc_ra     = anc_rd;
                end
            end
            U_0:
            begin
                if (ctop_reg == '0)
                begin
                    anc_ra     = ev_reg;
                    state_next = E_3;
                end
                else
                begin
                    stack_ra   = ctop_reg - AW'(1);
                    ctop_next  = ctop_reg - AW'(1);
                    state_next = U_1;
                end
            end
            U_1:
            begin
                u_next     = stack_rd[AW-1:0];
                anc_ra     = stack_rd[AW-1:0];
                state_next = U_2;
            end
            U_2:
            begin
                a_next     = anc_rd;
                label_ra   = anc_rd;
                state_next = U_3;
            end
            U_3:
            begin
                la_next    = label_rd;
                anc_ra     = a_reg;
                label_ra   = u_reg;
                state_next = U_4;
            end
            U_4:
            begin
                aa_next    = anc_rd;
                lu_next    = label_rd;
                semi_ra    = la_reg;
                state_next = U_5;
            end
            U_5:
            begin
                sla_next   = semi_rd;
                semi_ra    = lu_reg;
                state_next = U_6;
            end
            U_6:
            begin
                if (sla_reg < semi_rd)
                begin
                    label_we = 1'b1;
                    label_wa = u_reg;
                    label_wd = la_reg;
                end
                anc_we     = 1'b1;
                anc_wa     = u_reg;
                anc_wd     = aa_reg;
                state_next = U_0;
            end
            E_3:
            begin
                a_next     = anc_rd;
                label_ra   = anc_rd;
                state_next = E_4;
            end
            E_4:
            begin
                la_next    = label_rd;
                label_ra   = ev_reg;
                state_next = E_5;
            end
            E_5:
            begin
                lu_next    = label_rd;
                semi_ra    = la_reg;
                state_next = E_6;
            end
            E_6:
            begin
                sla_next   = semi_rd;
                semi_ra    = lu_reg;
                state_next = E_7;
            end
            E_7:
            begin
                res        = (sla_reg >= semi_rd) ? lu_reg : la_reg;
                er_next    = res;
                semi_ra    = res;
                state_next = ret_bucket_reg ? K_4 : P_UPD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (visit_en)
        begin
            semi_we   = 1'b1; semi_wa   = vis_v;   semi_wd   = vis_num;
            vertex_we = 1'b1; vertex_wa = vis_num; vertex_wd = vis_v;
            label_we  = 1'b1; label_wa  = vis_v;   label_wd  = vis_v;
            anc_we    = 1'b1; anc_wa    = vis_v;   anc_wd    = '0;
            child_we  = 1'b1; child_wa  = vis_v;   child_wd  = '0;
            size_we   = 1'b1; size_wa   = vis_v;   size_wd   = AW'(1);
        end
    end

endmodule

// ===== hw/rtl/dtb_checker.sv =====
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks of the dominator tree builder, bound to the top level.
// ----------------------------------------------------------------------------
module dtb_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               command,
    input  logic                     done,
    input  logic [1:0]               status,
    input  logic [dtb_pkg::FW-1:0]   immediate_dominator,
    input  logic                     has_dominator,
    input  logic                     reachable
);

    import dtb_pkg::*;

    // a clear word answers ok in the next cycle
    a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_CLEAR) |=> done && (status == ST_OK))
        else $error("clear word not answered");

    // compute holds the command port off right away
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_COMPUTE) |=> busy && !done)
        else $error("compute did not go busy");

    a_dom_reach: assert property (@(posedge clk) disable iff (!rst_n)
        done && has_dominator |-> reachable)
        else $error("dominator on unreachable node");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> !reachable && !has_dominator
            && (immediate_dominator == '0))
        else $error("failed word carries data");

endmodule

bind dominator_tree_builder dtb_checker u_dtb_checker (.*);

// ===== tb/dominator_tree_builder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dominator_tree_builder_tb
// Drives clear, add, compute and query words into the dominator tree builder
// and checks every result against an independent dominator predictor built
// on iterative dominator sets, across several node counts and edge stores.
// ----------------------------------------------------------------------------
module dominator_tree_builder_tb;
    import dtb_pkg::*;

    localparam int LIMIT = 1500000;

    typedef struct packed {
        status_t    st;
        logic [7:0] idom;
        logic       has_dom;
        logic       reach;
    } answer_t;

    class dom_scoreboard;
        int unsigned count_reg;
        logic [7:0]  src_q[$];
        logic [7:0]  dst_q[$];
        bit          ready_flag;
        bit          reach_tab[256];
        logic [7:0]  idom_tab[256];
        answer_t     answers[$];

        function new();
            count_reg  = 1;
            ready_flag = 0;
        endfunction

        function int unsigned nodes();
            if (count_reg < 1) return 1;
            if (count_reg > MAX_NODES) return MAX_NODES;
            return count_reg;
        endfunction

        function void set_count(int unsigned v);
            count_reg  = v;
            ready_flag = 0;
        endfunction

        function void solve_tree();
            int unsigned n;
            logic [255:0] dom_set[256];
            logic [255:0] nxt;
            bit           changed;
            int           best;
            n = nodes();
            foreach (reach_tab[i]) reach_tab[i] = 0;
            reach_tab[0] = 1;
            changed = 1;
            while (changed) begin
                changed = 0;
                foreach (src_q[e])
                    if (src_q[e] < n && dst_q[e] < n && reach_tab[src_q[e]]
                        && !reach_tab[dst_q[e]]) begin
                        reach_tab[dst_q[e]] = 1;
                        changed = 1;
                    end
            end
            for (int v = 0; v < 256; v++) dom_set[v] = '1;
            dom_set[0] = 256'd1;
            changed = 1;
            while (changed) begin
                changed = 0;
                for (int v = 1; v < n; v++) begin
                    if (!reach_tab[v]) continue;
                    nxt = '1;
                    foreach (src_q[e])
                        if (dst_q[e] == v && src_q[e] < n && reach_tab[src_q[e]])
                            nxt &= dom_set[src_q[e]];
                    nxt[v] = 1'b1;
                    if (nxt != dom_set[v]) begin
                        dom_set[v] = nxt;
                        changed = 1;
                    end
                end
            end
            for (int v = 0; v < 256; v++) begin
                idom_tab[v] = 0;
                if (v == 0 || v >= n || !reach_tab[v]) continue;
                best = -1;
                for (int d = 0; d < n; d++)
                    if (d != v && dom_set[v][d] && (best < 0 ||
                        $countones(dom_set[d]) > $countones(dom_set[best])))
                        best = d;
                idom_tab[v] = best[7:0];
            end
            ready_flag = 1;
        endfunction

        function void note(cmd_t cmd, logic [7:0] s, logic [7:0] t, logic [7:0] q);
            answer_t a;
            int unsigned n;
            a = '0;
            n = nodes();
            case (cmd)
                CMD_CLEAR: begin
                    src_q.delete();
                    dst_q.delete();
                    ready_flag = 0;
                end
                CMD_ADD: begin
                    if (s >= n || t >= n) a.st = ST_RANGE;
                    else if (src_q.size() >= MAX_EDGES) a.st = ST_FULL;
                    else begin
                        src_q.push_back(s);
                        dst_q.push_back(t);
                        ready_flag = 0;
                    end
                end
                CMD_COMPUTE: solve_tree();
                default: begin
                    if (q >= n) a.st = ST_RANGE;
                    else if (!ready_flag) a.st = ST_NOT_DONE;
                    else if (q == 0) a.reach = 1;
                    else if (reach_tab[q]) begin
                        a.idom = idom_tab[q];
                        a.has_dom = 1;
                        a.reach = 1;
                    end
                end
            endcase
            answers.push_back(a);
        endfunction

        function string check(answer_t got);
            answer_t w;
            if (answers.size() == 0) return "result with no word pending";
            w = answers.pop_front();
            if (got !== w)
                return $sformatf("status %0d/%0d idom %0d/%0d has %0d/%0d reach %0d/%0d",
                    got.st, w.st, got.idom, w.idom, got.has_dom, w.has_dom,
                    got.reach, w.reach);
            return "";
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] command;
    logic [7:0] edge_source;
    logic [7:0] edge_target;
    logic [7:0] query_node;
    logic       done;
    logic [1:0] status;
    logic [7:0] immediate_dominator;
    logic       has_dominator;
    logic       reachable;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] cfg_data;

    dom_scoreboard sb = new();
    int errors = 0;
    int cycles = 0;

    dominator_tree_builder dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .edge_source(edge_source), .edge_target(edge_target),
        .query_node(query_node), .done(done), .status(status),
        .immediate_dominator(immediate_dominator), .has_dominator(has_dominator),
        .reachable(reachable), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && done)
        begin
            msg = sb.check({status_t'(status), immediate_dominator, has_dominator,
                reachable});
            if (msg != "") report(msg);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(cmd_t cmd, int s, int t, int q);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        edge_source <= 8'(s);
        edge_target <= 8'(t);
        query_node  <= 8'(q);
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note(cmd, 8'(s), 8'(t), 8'(q));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.answers.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_count(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[8:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_count(v[8:0]);
    endtask

    task automatic query_all(int unsigned n);
        if (n <= 24)
            for (int v = 0; v <= n && v < 256; v++) send(CMD_QUERY, 0, 0, v);
        else
        begin
            send(CMD_QUERY, 0, 0, 0);
            send(CMD_QUERY, 0, 0, int'(n) - 1);
            repeat (20) send(CMD_QUERY, 0, 0, $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int unsigned n;
        int items;
        int edges;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        command     <= CMD_CLEAR;
        edge_source <= '0;
        edge_target <= '0;
        query_node  <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, one node
        send(CMD_QUERY, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 1);
        send(CMD_ADD, 0, 0, 0);
        send(CMD_ADD, 0, 1, 0);
        send(CMD_COMPUTE, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 0);

        // oversize count acts as the maximum
        write_count(511);
        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_ADD, 0, 255, 0);
        send(CMD_ADD, 255, 128, 0);
        send(CMD_ADD, 128, 1, 0);
        send(CMD_ADD, 0, 1, 0);
        send(CMD_ADD, 1, 255, 0);
        send(CMD_ADD, 254, 200, 0);
        send(CMD_ADD, 200, 1, 0);
        send(CMD_QUERY, 0, 0, 1);
        send(CMD_COMPUTE, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 255);
        send(CMD_QUERY, 0, 0, 128);
        send(CMD_QUERY, 0, 0, 1);
        send(CMD_QUERY, 0, 0, 200);
        send(CMD_QUERY, 0, 0, 254);

        // zero count acts as one, stale edges ignored
        write_count(0);
        send(CMD_COMPUTE, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 1);

        // full edge store
        write_count(2);
        send(CMD_CLEAR, 0, 0, 0);
        repeat (MAX_EDGES + 1) send(CMD_ADD, $urandom_range(0, 1), $urandom_range(0, 1), 0);
        send(CMD_ADD, 2, 0, 0);
        send(CMD_COMPUTE, 0, 0, 0);
        query_all(2);
        send(CMD_CLEAR, 0, 0, 0);

        items = 0;
        while (items < 500)
        begin
            case ($urandom_range(0, 9))
                0: n = 256;
                1: n = $urandom_range(257, 511);
                2: n = $urandom_range(0, 1);
                default: n = $urandom_range(2, 16);
            endcase
            write_count(n);
            n = sb.nodes();
            if ($urandom_range(0, 3) != 0)
            begin
                send(CMD_CLEAR, 0, 0, 0);
                items++;
            end
            edges = (n > 16) ? $urandom_range(5, 30) : $urandom_range(0, 3 * n + 4);
            if ($urandom_range(0, 4) == 0)
            begin
                send(CMD_QUERY, 0, 0, $urandom_range(0, 255));
                items++;
            end
            for (int e = 0; e < edges; e++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(CMD_ADD, $urandom_range(0, 255), $urandom_range(0, 255), 0);
                else
                    send(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
                items++;
            end
            send(CMD_COMPUTE, 0, 0, 0);
            query_all(n);
            items += (n <= 24) ? int'(n) + 2 : 23;
            if ($urandom_range(0, 2) == 0)
            begin
                send(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
                send(CMD_QUERY, 0, 0, $urandom_range(0, n - 1));
                items += 2;
            end
        end
        send(CMD_CLEAR, 0, 0, 0);

        drain();
        repeat (20) @(posedge clk);
        if (sb.answers.size() != 0) report("results still pending at end");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
